// ===== design/hrht_pkg.sv =====
// Shared types, codes and constants for the HTTP request head tokenizer.
// Depends on nothing; every module of the block refers to it by scoped names.
`timescale 1ns / 1ps

package hrht_pkg;

  localparam int MethodScanBytes = 16;
  localparam int OffsetBits      = 16;
  localparam int MethodCountBits = $clog2(MethodScanBytes + 1);
  localparam int MethodMaxLen    = 7;
  localparam int NumMethods      = 9;

  localparam int OutDepth   = 4;
  localparam int OutPtrBits = $clog2(OutDepth);
  localparam int OutCntBits = $clog2(OutDepth + 1);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] CaseGap = 8'h20;

  localparam logic [2:0] KindDelim   = 3'd0;
  localparam logic [2:0] KindMethod  = 3'd1;
  localparam logic [2:0] KindUrl     = 3'd2;
  localparam logic [2:0] KindVersion = 3'd3;
  localparam logic [2:0] KindName    = 3'd4;
  localparam logic [2:0] KindValue   = 3'd5;
  localparam logic [2:0] KindSkip    = 3'd6;
  localparam logic [2:0] KindBody    = 3'd7;

  localparam logic [2:0] StRunning      = 3'd0;
  localparam logic [2:0] StOk           = 3'd1;
  localparam logic [2:0] StNoMethodEnd  = 3'd2;
  localparam logic [2:0] StBadMethod    = 3'd3;
  localparam logic [2:0] StNoUrlEnd     = 3'd4;
  localparam logic [2:0] StNoVersionEnd = 3'd5;
  localparam logic [2:0] StHeadPartial  = 3'd6;

  localparam logic [3:0] MethodNone = 4'd0;

  // Method names packed with the first character in the lowest byte.
  localparam logic [55:0] MethodPat [NumMethods] = '{
    56'h00000000544547,   // GET
    56'h00000054534F50,   // POST
    56'h00000000545550,   // PUT
    56'h004554454C4544,   // DELETE
    56'h00000044414548,   // HEAD
    56'h534E4F4954504F,   // OPTIONS
    56'h00004843544150,   // PATCH
    56'h00004543415254,   // TRACE
    56'h5443454E4E4F43    // CONNECT
  };

  localparam logic [3:0] MethodLen [NumMethods] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd5, 4'd7
  };

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } req_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  kind;
    logic [2:0]  status;
    logic [3:0]  method_code;
    logic [15:0] head_end_offset;
    logic        last_out;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic [3:0] match_method(input logic [55:0] bytes,
                                              input logic [MethodCountBits-1:0] count);
    logic [3:0] code;
    code = MethodNone;
    for (int m = 0; m < NumMethods; m++) begin
      if ((count == MethodCountBits'(MethodLen[m])) && (bytes == MethodPat[m])) begin
        code = 4'(m + 1);
      end
    end
    return code;
  endfunction

endpackage

// ===== design/hrht_out_fifo.sv =====
// Result queue of the tokenizer: takes up to two result items a cycle and
// hands out one a cycle while out_ready_i is high. Depends on hrht_pkg.
`timescale 1ns / 1ps

module hrht_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hrht_pkg::push_t push_i,
  output logic           room2_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hrht_pkg::res_t out_data_o
);

  hrht_pkg::res_t mem_q [hrht_pkg::OutDepth];

  logic [hrht_pkg::OutPtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [hrht_pkg::OutCntBits-1:0] count_q, count_d, n_push;
  logic                            pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room2_o     = (count_q <= hrht_pkg::OutCntBits'(hrht_pkg::OutDepth - 2));
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    n_push    = hrht_pkg::OutCntBits'(push_i.v0) + hrht_pkg::OutCntBits'(push_i.v1);
    wr_ptr_nx = wr_ptr_q + hrht_pkg::OutPtrBits'(1);
    wr_ptr_d  = wr_ptr_q + n_push[hrht_pkg::OutPtrBits-1:0];
    rd_ptr_d  = pop ? rd_ptr_q + hrht_pkg::OutPtrBits'(1) : rd_ptr_q;
    count_d   = count_q + n_push - hrht_pkg::OutCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

endmodule

// ===== design/hrht_core.sv =====
// Input register, parse state and per-byte labeling logic of the tokenizer.
// Produces up to two result items per byte. Depends on hrht_pkg.
`timescale 1ns / 1ps

module hrht_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hrht_pkg::req_t  in_data_i,
  input  logic            room2_i,
  output hrht_pkg::push_t push_o
);

  localparam logic [2:0] PhMethod  = 3'd0;
  localparam logic [2:0] PhUrl     = 3'd1;
  localparam logic [2:0] PhVersion = 3'd2;
  localparam logic [2:0] PhLstart  = 3'd3;
  localparam logic [2:0] PhName    = 3'd4;
  localparam logic [2:0] PhValue   = 3'd5;
  localparam logic [2:0] PhBody    = 3'd6;
  localparam logic [2:0] PhError   = 3'd7;

  localparam int Mcb = hrht_pkg::MethodCountBits;
  localparam int Ob  = hrht_pkg::OffsetBits;

  logic           in_v_q;
  hrht_pkg::req_t in_q;
  logic           fire;

  logic [2:0]    phase_q, phase_d;
  logic [55:0]   mbytes_q, mbytes_d;
  logic [Mcb-1:0] mcount_q, mcount_d;
  logic          held_v_q, held_v_d;
  logic          held_colon_q, held_colon_d;
  logic          sep_q, sep_d;
  logic [Ob-1:0] ofs_q, ofs_d;
  logic [2:0]    err_q, err_d;
  logic [3:0]    fm_q, fm_d;

  logic [7:0]  b, hb, a_byte, b_byte, c_byte;
  logic [2:0]  a_kind, b_kind, c_kind, st;
  logic        a_v, b_v, c_v, consumed, last;
  logic [31:0] ofs_wide;
  logic [15:0] head_end;
  hrht_pkg::res_t ra, rb, rc, summ0, summ1;

  function automatic logic [2:0] field_kind(input logic [2:0] ph);
    logic [2:0] k;
    unique case (ph)
      PhVersion:        k = hrht_pkg::KindVersion;
      PhLstart, PhName: k = hrht_pkg::KindName;
      PhValue:          k = hrht_pkg::KindValue;
      default:          k = hrht_pkg::KindDelim;
    endcase
    return k;
  endfunction

  function automatic hrht_pkg::res_t mk(input logic [7:0] by, input logic [2:0] kd);
    hrht_pkg::res_t r;
    r                 = '0;
    r.byte_out        = by;
    r.kind            = kd;
    return r;
  endfunction

  assign fire       = in_v_q && room2_i;
  assign in_ready_o = !in_v_q || room2_i;

  always_comb begin
    phase_d      = phase_q;
    mbytes_d     = mbytes_q;
    mcount_d     = mcount_q;
    held_v_d     = held_v_q;
    held_colon_d = held_colon_q;
    sep_d        = sep_q;
    ofs_d        = ofs_q;
    err_d        = err_q;
    fm_d         = fm_q;

    b    = in_q.byte_in;
    last = in_q.last_in;
    hb   = held_colon_q ? hrht_pkg::ChColon : hrht_pkg::ChCr;

    a_v = 1'b0; a_byte = hb; a_kind = hrht_pkg::KindDelim;
    b_v = 1'b0; b_byte = b;  b_kind = hrht_pkg::KindDelim;
    c_v = 1'b0; c_byte = hb; c_kind = hrht_pkg::KindDelim;
    consumed = 1'b0;

    if ((phase_q != PhBody) && (ofs_q != {Ob{1'b1}})) begin
      ofs_d = ofs_q + Ob'(1);
    end

    if (held_v_q) begin
      held_v_d = 1'b0;
      if (!held_colon_q) begin
        if (b == hrht_pkg::ChLf) begin
          a_v    = 1'b1;
          a_kind = ((phase_d == PhName) && !sep_d) ? hrht_pkg::KindSkip
                                                   : hrht_pkg::KindDelim;
          b_v    = 1'b1;
          b_kind = a_kind;
          if (phase_d == PhLstart) begin
            phase_d = PhBody;
          end else begin
            phase_d = PhLstart;
            sep_d   = 1'b0;
          end
          consumed = 1'b1;
        end else begin
          a_v    = 1'b1;
          a_kind = field_kind(phase_d);
          if (phase_d == PhLstart) begin
            phase_d = PhName;
          end
        end
      end else begin
        a_v = 1'b1;
        if (b == hrht_pkg::ChSpace) begin
          a_kind   = hrht_pkg::KindDelim;
          b_v      = 1'b1;
          b_kind   = hrht_pkg::KindDelim;
          phase_d  = PhValue;
          sep_d    = 1'b1;
          consumed = 1'b1;
        end else begin
          a_kind = hrht_pkg::KindName;
        end
      end
    end

    if (!consumed) begin
      unique case (phase_d)
        PhMethod: begin
          b_v = 1'b1;
          if (b == hrht_pkg::ChSpace) begin
            b_kind = hrht_pkg::KindDelim;
            fm_d   = hrht_pkg::match_method(mbytes_q, mcount_q);
            if (fm_d == hrht_pkg::MethodNone) begin
              err_d   = hrht_pkg::StBadMethod;
              phase_d = PhError;
            end else begin
              phase_d = PhUrl;
            end
          end else begin
            b_kind = hrht_pkg::KindMethod;
            for (int i = 0; i < hrht_pkg::MethodMaxLen; i++) begin
              if (mcount_q == Mcb'(i)) begin
                mbytes_d[8*i +: 8] = b;
              end
            end
            mcount_d = mcount_q + Mcb'(1);
            if (mcount_d >= Mcb'(hrht_pkg::MethodScanBytes)) begin
              err_d   = hrht_pkg::StNoMethodEnd;
              phase_d = PhError;
            end
          end
        end
        PhUrl: begin
          b_v    = 1'b1;
          b_kind = (b == hrht_pkg::ChSpace) ? hrht_pkg::KindDelim : hrht_pkg::KindUrl;
          if (b == hrht_pkg::ChSpace) begin
            phase_d = PhVersion;
          end
        end
        PhVersion, PhValue: begin
          if (b == hrht_pkg::ChCr) begin
            held_v_d     = 1'b1;
            held_colon_d = 1'b0;
          end else begin
            b_v    = 1'b1;
            b_kind = field_kind(phase_d);
          end
        end
        PhLstart, PhName: begin
          if (b == hrht_pkg::ChCr) begin
            held_v_d     = 1'b1;
            held_colon_d = 1'b0;
          end else if (b == hrht_pkg::ChColon) begin
            phase_d      = PhName;
            held_v_d     = 1'b1;
            held_colon_d = 1'b1;
          end else begin
            phase_d = PhName;
            b_v     = 1'b1;
            b_kind  = hrht_pkg::KindName;
            b_byte  = ((b >= hrht_pkg::ChUpA) && (b <= hrht_pkg::ChUpZ))
                      ? b + hrht_pkg::CaseGap : b;
          end
        end
        PhBody: begin
          b_v    = 1'b1;
          b_kind = hrht_pkg::KindBody;
        end
        default: begin
          b_v    = 1'b1;
          b_kind = hrht_pkg::KindDelim;
        end
      endcase
    end

    st = hrht_pkg::StRunning;
    if (last) begin
      if (held_v_d) begin
        c_v    = 1'b1;
        c_byte = held_colon_d ? hrht_pkg::ChColon : hrht_pkg::ChCr;
        c_kind = field_kind(phase_d);
      end
      priority if (err_d != hrht_pkg::StRunning) st = err_d;
      else if (phase_d == PhBody)                st = hrht_pkg::StOk;
      else if (phase_d == PhMethod)              st = hrht_pkg::StNoMethodEnd;
      else if (phase_d == PhUrl)                 st = hrht_pkg::StNoUrlEnd;
      else if (phase_d == PhVersion)             st = hrht_pkg::StNoVersionEnd;
      else                                       st = hrht_pkg::StHeadPartial;

      phase_d      = PhMethod;
      mbytes_d     = '0;
      mcount_d     = '0;
      held_v_d     = 1'b0;
      held_colon_d = 1'b0;
      sep_d        = 1'b0;
      err_d        = hrht_pkg::StRunning;
      fm_d         = hrht_pkg::MethodNone;
    end
  end

  always_comb begin
    ofs_wide = 32'(ofs_d);
    head_end = (ofs_wide > 32'h0000_FFFF) ? 16'hFFFF : ofs_wide[15:0];
  end

  always_comb begin
    ra = mk(a_byte, a_kind);
    rb = mk(b_byte, b_kind);
    rc = mk(c_byte, c_kind);

    push_o.v0 = fire && (a_v || b_v || c_v);
    push_o.v1 = fire && (a_v ? (b_v || c_v) : (b_v && c_v));
    summ0     = a_v ? ra : (b_v ? rb : rc);
    summ1     = (a_v && b_v) ? rb : rc;

    if (last) begin
      if (push_o.v1) begin
        summ1.status          = st;
        summ1.method_code     = fm_q | ((phase_q == PhMethod) ? hrht_pkg::match_method(
                                  mbytes_q, mcount_q) & {4{b == hrht_pkg::ChSpace}} : 4'd0);
        summ1.head_end_offset = (st == hrht_pkg::StOk) ? head_end : 16'd0;
        summ1.last_out        = 1'b1;
      end else begin
        summ0.status          = st;
        summ0.method_code     = fm_q | ((phase_q == PhMethod) ? hrht_pkg::match_method(
                                  mbytes_q, mcount_q) & {4{b == hrht_pkg::ChSpace}} : 4'd0);
        summ0.head_end_offset = (st == hrht_pkg::StOk) ? head_end : 16'd0;
        summ0.last_out        = 1'b1;
      end
    end

    push_o.r0 = summ0;
    push_o.r1 = summ1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhMethod;
      mbytes_q     <= '0;
      mcount_q     <= '0;
      held_v_q     <= 1'b0;
      held_colon_q <= 1'b0;
      sep_q        <= 1'b0;
      ofs_q        <= '0;
      err_q        <= hrht_pkg::StRunning;
      fm_q         <= hrht_pkg::MethodNone;
    end else if (fire) begin
      phase_q      <= phase_d;
      mbytes_q     <= mbytes_d;
      mcount_q     <= mcount_d;
      held_v_q     <= held_v_d;
      held_colon_q <= held_colon_d;
      sep_q        <= sep_d;
      ofs_q        <= in_q.last_in ? '0 : ofs_d;
      err_q        <= err_d;
      fm_q         <= fm_d;
    end
  end

endmodule

// ===== design/http_request_head_tokenizer.sv =====
// Top level of the HTTP request head tokenizer: input register and labeling
// core feeding a four-entry result queue. Depends on hrht_pkg, hrht_core, hrht_out_fifo.
`timescale 1ns / 1ps

// The block accepts one request byte per cycle and labels it once it is held in
// the input register, and its results are written into the result queue. A byte
// yields zero, one or two result items, because colon and CR bytes are held back
// one byte; results leave a four-entry queue one per cycle while out_ready_i is high,
// and input is stalled whenever fewer than two queue entries are free. The summary
// fields ride on the last result item of the final byte, after which the parse
// state is back at its reset value for the next buffer.
module http_request_head_tokenizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hrht_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hrht_pkg::res_t out_data_o
);

  hrht_pkg::push_t push;
  logic            room2;

  hrht_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .room2_i    (room2),
    .push_o     (push)
  );

  hrht_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
